>>> rtl/qrgs_pkg.sv
// ----------------------------------------------------------------------------
// qrgs_pkg
// Shared widths and register indexes for the Gram-Schmidt QR block.
// ----------------------------------------------------------------------------
package qrgs_pkg;

  localparam int DATA_W = 32;
  localparam int ROW_W  = 3;
  localparam int COL_W  = 2;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_THRESH = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

>>> rtl/qrgs_ram.sv
// ----------------------------------------------------------------------------
// qrgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qrgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/qr_decomposition_gram_schmidt.sv
// ----------------------------------------------------------------------------
// qr_decomposition_gram_schmidt
// Thin QR of an m by n Q16.16 matrix by modified Gram-Schmidt.
// Loading: one item per cycle, m*n items; in_stall rises after the last one.
// Run: per column j, MACs on one RAM read port (read, read, multiply, accumulate),
//   a 32-step root and a 48-step divide; then each result is read, loaded and
//   held through output stalls; next matrix loads after the last result is taken.
// Reset (synchronous, rst_n low): sizes 8x4, threshold 0, load count cleared.
// ----------------------------------------------------------------------------
module qr_decomposition_gram_schmidt #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_element_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_result_value,
  output logic                         out_which_matrix,
  output logic [qrgs_pkg::ROW_W-1:0]   out_row_index,
  output logic [qrgs_pkg::COL_W-1:0]   out_col_index,
  output logic                         out_status,
  output logic                         out_last_result,
  input  logic                         cfg_we,
  input  logic [qrgs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [qrgs_pkg::CFG_W-1:0]   cfg_data
);
  import qrgs_pkg::*;

  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int RDEPTH = MAX_COLS * MAX_COLS;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DOT_RD, S_DOT_RD2, S_DOT_MUL, S_DOT_ACC, S_DOT_END,
    S_UPD_RD, S_UPD_RD2, S_UPD_MUL, S_UPD_SUB, S_SQRT, S_SQRT_END,
    S_DIV_RD, S_DIV_LOAD, S_DIV_ITER, S_DIV_WR, S_ZERO_WR,
    S_OUT_RD, S_OUT_LOAD, S_OUT_HOLD
  } state_t;

  function automatic logic [WA_W-1:0] waddr_f(input logic [COL_W-1:0] c,
                                               input logic [ROW_W-1:0] r);
    return WA_W'(int'(c) * MAX_ROWS + int'(r));
  endfunction

  function automatic logic [RA_W-1:0] raddr_f(input logic [COL_W-1:0] c,
                                              input logic [ROW_W-1:0] r);
    return RA_W'(int'(c) * MAX_COLS + int'(r));
  endfunction

  function automatic logic signed [47:0] rnd_f(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [31:0] sat32_f(input logic signed [48:0] s);
    logic signed [31:0] res;
    if (s > 49'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (s < -49'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [47:0] sat48_f(input logic signed [48:0] s);
    logic signed [47:0] res;
    if (s[48] != s[47]) begin
      res = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      res = s[47:0];
    end
    return res;
  endfunction

  state_t              state_r, state_nxt;
  logic [3:0]          rows_r, rows_nxt;
  logic [2:0]          cols_r, cols_nxt;
  logic [15:0]         thr_r, thr_nxt;
  logic [ROW_W-1:0]    ld_row_r, ld_row_nxt;
  logic [COL_W-1:0]    ld_col_r, ld_col_nxt;
  logic [COL_W-1:0]    j_r, j_nxt, i_r, i_nxt, oc_r, oc_nxt;
  logic [ROW_W-1:0]    k_r, k_nxt, orow_r, orow_nxt;
  logic                omat_r, omat_nxt;
  logic signed [47:0]  acc_r, acc_nxt;
  logic signed [31:0]  a_r, a_nxt, q_r, q_nxt, rr_r, rr_nxt;
  logic signed [63:0]  prod_r, prod_nxt;
  logic [63:0]         x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [5:0]          it_r, it_nxt;
  logic                sign_r, sign_nxt;
  logic [47:0]         dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [30:0]         norm_r, norm_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  out_value_r, out_value_nxt;
  logic                out_which_r, out_which_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic                wm_we, rm_we;
  logic [WA_W-1:0]     wm_waddr, wm_raddr;
  logic [RA_W-1:0]     rm_waddr, rm_raddr;
  logic [31:0]         wm_wdata, rm_wdata, wm_rdata, rm_rdata;

  logic [3:0]          m_eff;
  logic [2:0]          n_eff;
  logic [ROW_W-1:0]    m_last;
  logic [COL_W-1:0]    n_last;
  logic signed [47:0]  term;
  logic signed [31:0]  norm_sat;
  logic [31:0]         mag;
  logic [32:0]         rs;
  logic [64:0]         trial;
  logic signed [31:0]  div_res;

  qrgs_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_work_ram (
    .clk(clk), .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
    .raddr(wm_raddr), .rdata(wm_rdata)
  );

  qrgs_ram #(.WIDTH(DATA_W), .DEPTH(RDEPTH)) u_tri_ram (
    .clk(clk), .we(rm_we), .waddr(rm_waddr), .wdata(rm_wdata),
    .raddr(rm_raddr), .rdata(rm_rdata)
  );

  always_comb begin
    if (rows_r == 4'd0) begin
      m_eff = 4'd1;
    end else if (int'(rows_r) > MAX_ROWS) begin
      m_eff = 4'(MAX_ROWS);
    end else begin
      m_eff = rows_r;
    end
    if (cols_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (int'(cols_r) > MAX_COLS) begin
      n_eff = 3'(MAX_COLS);
    end else begin
      n_eff = cols_r;
    end
  end

  assign m_last   = ROW_W'(m_eff - 4'd1);
  assign n_last   = COL_W'(n_eff - 3'd1);
  assign term     = rnd_f(prod_r);
  assign norm_sat = (res_r[63:31] != '0) ? 32'sh7FFFFFFF : $signed(res_r[31:0]);
  assign mag      = wm_rdata[31] ? (32'd0 - wm_rdata) : wm_rdata;
  assign rs       = {rem_r, dvd_r[47]};
  assign trial    = {1'b0, res_r} + {1'b0, bit_r};

  always_comb begin
    if (sign_r) begin
      div_res = (quo_r > 48'd2147483648) ? 32'sh80000000 : $signed(32'd0 - quo_r[31:0]);
    end else begin
      div_res = (quo_r > 48'd2147483647) ? 32'sh7FFFFFFF : $signed(quo_r[31:0]);
    end
  end

  always_comb begin
    unique case (state_r)
      S_DOT_RD, S_UPD_RD: wm_raddr = waddr_f(i_r, k_r);
      S_OUT_RD:           wm_raddr = waddr_f(oc_r, orow_r);
      default:            wm_raddr = waddr_f(j_r, k_r);
    endcase
  end
  assign rm_raddr = raddr_f(oc_r, orow_r);

  always_comb begin
    state_nxt      = state_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    thr_nxt        = thr_r;
    ld_row_nxt     = ld_row_r;
    ld_col_nxt     = ld_col_r;
    j_nxt          = j_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    oc_nxt         = oc_r;
    orow_nxt       = orow_r;
    omat_nxt       = omat_r;
    acc_nxt        = acc_r;
    a_nxt          = a_r;
    q_nxt          = q_r;
    rr_nxt         = rr_r;
    prod_nxt       = prod_r;
    x_nxt          = x_r;
    res_nxt        = res_r;
    bit_nxt        = bit_r;
    it_nxt         = it_r;
    sign_nxt       = sign_r;
    dvd_nxt        = dvd_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    norm_nxt       = norm_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_which_nxt  = out_which_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wm_we          = 1'b0;
    wm_waddr       = waddr_f(j_r, k_r);
    wm_wdata       = '0;
    rm_we          = 1'b0;
    rm_waddr       = raddr_f(j_r, ROW_W'(i_r));
    rm_wdata       = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: begin
          rows_nxt   = cfg_data[3:0];
          ld_row_nxt = '0;
          ld_col_nxt = '0;
        end
        CFG_COLS: begin
          cols_nxt   = cfg_data[2:0];
          ld_row_nxt = '0;
          ld_col_nxt = '0;
        end
        CFG_THRESH: thr_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wm_we    = 1'b1;
          wm_waddr = waddr_f(ld_col_r, ld_row_r);
          wm_wdata = in_element_value;
          if (ld_row_r == m_last) begin
            ld_row_nxt = '0;
            if (ld_col_r == n_last) begin
              ld_col_nxt = '0;
              if (m_eff < {1'b0, n_eff}) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_which_nxt  = 1'b0;
                out_row_nxt    = '0;
                out_col_nxt    = '0;
                out_status_nxt = 1'b1;
                out_last_nxt   = 1'b1;
                state_nxt      = S_OUT_HOLD;
              end else begin
                j_nxt     = '0;
                i_nxt     = '0;
                k_nxt     = '0;
                acc_nxt   = '0;
                state_nxt = S_DOT_RD;
              end
            end else begin
              ld_col_nxt = ld_col_r + 1'b1;
            end
          end else begin
            ld_row_nxt = ld_row_r + 1'b1;
          end
        end
      end
      S_DOT_RD:  state_nxt = S_DOT_RD2;
      S_DOT_RD2: begin
        a_nxt     = $signed(wm_rdata);
        state_nxt = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        prod_nxt  = a_r * $signed(wm_rdata);
        state_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        acc_nxt = sat48_f({acc_r[47], acc_r} + {term[47], term});
        if (k_r == m_last) begin
          k_nxt     = '0;
          state_nxt = S_DOT_END;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DOT_RD;
        end
      end
      S_DOT_END: begin
        if (i_r == j_r) begin
          x_nxt     = acc_r[47] ? 64'd0 : {1'b0, acc_r[46:0], 16'd0};
          res_nxt   = '0;
          bit_nxt   = 64'd1 << 62;
          it_nxt    = '0;
          state_nxt = S_SQRT;
        end else begin
          rr_nxt    = sat32_f({acc_r[47], acc_r});
          rm_we     = 1'b1;
          rm_waddr  = raddr_f(j_r, ROW_W'(i_r));
          rm_wdata  = sat32_f({acc_r[47], acc_r});
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD:  state_nxt = S_UPD_RD2;
      S_UPD_RD2: begin
        a_nxt     = $signed(wm_rdata);
        state_nxt = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        prod_nxt  = rr_r * a_r;
        q_nxt     = $signed(wm_rdata);
        state_nxt = S_UPD_SUB;
      end
      S_UPD_SUB: begin
        wm_we    = 1'b1;
        wm_waddr = waddr_f(j_r, k_r);
        wm_wdata = sat32_f({{17{q_r[31]}}, q_r} - {term[47], term});
        if (k_r == m_last) begin
          k_nxt     = '0;
          i_nxt     = i_r + 1'b1;
          acc_nxt   = '0;
          state_nxt = S_DOT_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_UPD_RD;
        end
      end
      S_SQRT: begin
        if (x_r >= trial[63:0]) begin
          x_nxt   = x_r - trial[63:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 1'b1;
        if (it_r == 6'd31) begin
          state_nxt = S_SQRT_END;
        end
      end
      S_SQRT_END: begin
        norm_nxt = norm_sat[30:0];
        rm_we    = 1'b1;
        rm_waddr = raddr_f(j_r, ROW_W'(j_r));
        rm_wdata = norm_sat;
        k_nxt    = '0;
        if ({1'b0, norm_sat[30:0]} > {16'd0, thr_r}) begin
          state_nxt = S_DIV_RD;
        end else begin
          state_nxt = S_ZERO_WR;
        end
      end
      S_DIV_RD:   state_nxt = S_DIV_LOAD;
      S_DIV_LOAD: begin
        sign_nxt  = wm_rdata[31];
        dvd_nxt   = {mag, 16'd0};
        rem_nxt   = '0;
        quo_nxt   = '0;
        it_nxt    = '0;
        state_nxt = S_DIV_ITER;
      end
      S_DIV_ITER: begin
        if (rs >= {2'b0, norm_r}) begin
          rem_nxt = 32'(rs - {2'b0, norm_r});
          quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          rem_nxt = rs[31:0];
          quo_nxt = {quo_r[46:0], 1'b0};
        end
        dvd_nxt = {dvd_r[46:0], 1'b0};
        it_nxt  = it_r + 1'b1;
        if (it_r == 6'd47) begin
          state_nxt = S_DIV_WR;
        end
      end
      S_DIV_WR, S_ZERO_WR: begin
        wm_we    = 1'b1;
        wm_waddr = waddr_f(j_r, k_r);
        wm_wdata = (state_r == S_DIV_WR) ? div_res : 32'd0;
        if (k_r == m_last) begin
          k_nxt = '0;
          if (j_r == n_last) begin
            oc_nxt    = '0;
            orow_nxt  = '0;
            omat_nxt  = 1'b0;
            state_nxt = S_OUT_RD;
          end else begin
            j_nxt     = j_r + 1'b1;
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_DOT_RD;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (state_r == S_DIV_WR) ? S_DIV_RD : S_ZERO_WR;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_LOAD;
      S_OUT_LOAD: begin
        out_valid_nxt  = 1'b1;
        out_which_nxt  = omat_r;
        out_row_nxt    = orow_r;
        out_col_nxt    = oc_r;
        out_status_nxt = 1'b0;
        if (omat_r) begin
          out_value_nxt = (orow_r > {1'b0, oc_r}) ? 32'sd0 : $signed(rm_rdata);
          out_last_nxt  = (oc_r == n_last) && (orow_r == {1'b0, n_last});
        end else begin
          out_value_nxt = $signed(wm_rdata);
          out_last_nxt  = 1'b0;
        end
        state_nxt = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OUT_RD;
            if (orow_r == (omat_r ? {1'b0, n_last} : m_last)) begin
              orow_nxt = '0;
              if (oc_r == n_last) begin
                oc_nxt   = '0;
                omat_nxt = 1'b1;
              end else begin
                oc_nxt = oc_r + 1'b1;
              end
            end else begin
              orow_nxt = orow_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= 4'd8;
      cols_r      <= 3'd4;
      thr_r       <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      thr_r       <= thr_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    j_r          <= j_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    oc_r         <= oc_nxt;
    orow_r       <= orow_nxt;
    omat_r       <= omat_nxt;
    acc_r        <= acc_nxt;
    a_r          <= a_nxt;
    q_r          <= q_nxt;
    rr_r         <= rr_nxt;
    prod_r       <= prod_nxt;
    x_r          <= x_nxt;
    res_r        <= res_nxt;
    bit_r        <= bit_nxt;
    it_r         <= it_nxt;
    sign_r       <= sign_nxt;
    dvd_r        <= dvd_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    norm_r       <= norm_nxt;
    out_value_r  <= out_value_nxt;
    out_which_r  <= out_which_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_which_matrix = out_which_r;
  assign out_row_index    = out_row_r;
  assign out_col_index    = out_col_r;
  assign out_status       = out_status_r;
  assign out_last_result  = out_last_r;

endmodule

>>> rtl/qrgs_checker.sv
// ----------------------------------------------------------------------------
// qrgs_checker
// Port-level checks for the Gram-Schmidt QR block.
// ----------------------------------------------------------------------------
module qrgs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [31:0]         in_element_value,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [31:0]         out_result_value,
  input logic                       out_which_matrix,
  input logic [qrgs_pkg::ROW_W-1:0] out_row_index,
  input logic [qrgs_pkg::COL_W-1:0] out_col_index,
  input logic                       out_status,
  input logic                       out_last_result,
  input logic                       cfg_we,
  input logic [qrgs_pkg::IDX_W-1:0] cfg_index,
  input logic [qrgs_pkg::CFG_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_result && (out_result_value == 0))
    else $error("error result malformed");

  a_r_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_which_matrix && (out_row_index > {1'b0, out_col_index})
      |-> out_result_value == 0)
    else $error("R below diagonal not zero");

  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

endmodule

bind qr_decomposition_gram_schmidt qrgs_checker u_qrgs_checker (.*);

>>> tb/qr_checker.sv
// ----------------------------------------------------------------------------
// qr_checker
// Watches the configuration port and both item channels of the Gram-Schmidt
// QR block, predicts every Q and R element in Q16.16 (or the error result)
// and compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module qr_checker #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [31:0]           in_element_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [31:0]           out_result_value,
  input  logic                         out_which_matrix,
  input  logic [qrgs_pkg::ROW_W-1:0]   out_row_index,
  input  logic [qrgs_pkg::COL_W-1:0]   out_col_index,
  input  logic                         out_status,
  input  logic                         out_last_result,
  input  logic                         cfg_we,
  input  logic [qrgs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [qrgs_pkg::CFG_W-1:0]   cfg_data,
  output int                           fail_count,
  output int                           pending_count
);
  import qrgs_pkg::*;

  typedef struct {
    word_t            value;
    logic             which;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             status;
    logic             last;
  } qr_elem_t;

  localparam longint SAT32_HI = 64'sd2147483647;
  localparam longint SAT32_LO = -64'sd2147483648;
  localparam longint SAT48_HI = (64'sd1 <<< 47) - 1;
  localparam longint SAT48_LO = -(64'sd1 <<< 47);

  logic [3:0]  rows_reg;
  logic [2:0]  cols_reg;
  logic [15:0] thresh_reg;
  longint      mat_store [MAX_ROWS*MAX_COLS];
  longint      tri_store [MAX_COLS*MAX_COLS];
  int          loaded;
  qr_elem_t    qr_expected [$];

  assign pending_count = qr_expected.size();

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint col_inner(int m, int a, int b);
    longint acc;
    acc = 0;
    for (int k = 0; k < m; k++)
      acc = clip(acc + fx_mul(mat_store[a*MAX_ROWS+k], mat_store[b*MAX_ROWS+k]),
                 SAT48_LO, SAT48_HI);
    return acc;
  endfunction

  function automatic longint int_root(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res > 64'd2147483647 ? SAT32_HI : longint'(res);
  endfunction

  function automatic int eff(int v, int mx);
    return v == 0 ? 1 : (v > mx ? mx : v);
  endfunction

  task automatic push(longint v, logic w, int r, int c, logic st, logic lst);
    qr_elem_t e;
    e.value = word_t'(v);
    e.which = w;
    e.row = r[ROW_W-1:0];
    e.col = c[COL_W-1:0];
    e.status = st;
    e.last = lst;
    qr_expected.push_back(e);
  endtask

  task automatic factor_matrix(int m, int n);
    longint rij, ss, nrm;
    for (int i = 0; i < MAX_COLS*MAX_COLS; i++) tri_store[i] = 0;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < j; i++) begin
        rij = clip(col_inner(m, i, j), SAT32_LO, SAT32_HI);
        tri_store[j*MAX_COLS+i] = rij;
        for (int k = 0; k < m; k++)
          mat_store[j*MAX_ROWS+k] = clip(mat_store[j*MAX_ROWS+k] -
                                         fx_mul(rij, mat_store[i*MAX_ROWS+k]),
                                         SAT32_LO, SAT32_HI);
      end
      ss = col_inner(m, j, j);
      if (ss < 0) ss = 0;
      nrm = int_root(longint'(ss) << 16);
      tri_store[j*MAX_COLS+j] = nrm;
      for (int k = 0; k < m; k++)
        if (nrm > longint'(thresh_reg))
          mat_store[j*MAX_ROWS+k] = clip((mat_store[j*MAX_ROWS+k] * 65536) / nrm,
                                         SAT32_LO, SAT32_HI);
        else
          mat_store[j*MAX_ROWS+k] = 0;
    end
    for (int c = 0; c < n; c++)
      for (int r = 0; r < m; r++)
        push(mat_store[c*MAX_ROWS+r], 1'b0, r, c, 1'b0, 1'b0);
    for (int c = 0; c < n; c++)
      for (int r = 0; r < n; r++)
        push(tri_store[c*MAX_COLS+r], 1'b1, r, c, 1'b0, c == n-1 && r == n-1);
  endtask

  task automatic load_element(longint v);
    int m, n;
    m = eff(rows_reg, MAX_ROWS);
    n = eff(cols_reg, MAX_COLS);
    if (loaded >= m*n) loaded = 0;
    mat_store[(loaded / m)*MAX_ROWS + (loaded % m)] = v;
    loaded++;
    if (loaded < m*n) return;
    loaded = 0;
    if (m < n) push(0, 1'b0, 0, 0, 1'b1, 1'b1);
    else factor_matrix(m, n);
  endtask

  task automatic compare(qr_elem_t got);
    qr_elem_t e;
    if (qr_expected.size() == 0) begin
      $error("unexpected result: value %0d which %0d row %0d col %0d",
             got.value, got.which, got.row, got.col);
      fail_count++;
      return;
    end
    e = qr_expected.pop_front();
    if (got.value !== e.value) begin
      $error("result_value: expected %0d actual %0d", e.value, got.value);
      fail_count++;
    end
    if (got.which !== e.which) begin
      $error("which_matrix: expected %0d actual %0d", e.which, got.which);
      fail_count++;
    end
    if (got.row !== e.row) begin
      $error("row_index: expected %0d actual %0d", e.row, got.row);
      fail_count++;
    end
    if (got.col !== e.col) begin
      $error("col_index: expected %0d actual %0d", e.col, got.col);
      fail_count++;
    end
    if (got.status !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, got.status);
      fail_count++;
    end
    if (got.last !== e.last) begin
      $error("last_result: expected %0d actual %0d", e.last, got.last);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    qr_elem_t got;
    if (!rst_n) begin
      rows_reg <= 4'd8;
      cols_reg <= 3'd4;
      thresh_reg <= '0;
      loaded = 0;
      qr_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: begin
            rows_reg <= cfg_data[3:0];
            loaded = 0;
          end
          CFG_COLS: begin
            cols_reg <= cfg_data[2:0];
            loaded = 0;
          end
          CFG_THRESH: thresh_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) load_element(longint'(in_element_value));
      if (out_valid && !out_stall) begin
        got.value = out_result_value;
        got.which = out_which_matrix;
        got.row = out_row_index;
        got.col = out_col_index;
        got.status = out_status;
        got.last = out_last_result;
        compare(got);
      end
    end
  end

endmodule

>>> tb/tb_qr_decomposition_gram_schmidt.sv
// ----------------------------------------------------------------------------
// tb_qr_decomposition_gram_schmidt
// Loads matrices of many sizes, thresholds and contents into the QR block
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_qr_decomposition_gram_schmidt;
  import qrgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_element_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result_value;
  logic               out_which_matrix;
  logic [ROW_W-1:0]   out_row_index;
  logic [COL_W-1:0]   out_col_index;
  logic               out_status;
  logic               out_last_result;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int                 fail_count;
  int                 pending_count;
  int                 idle_cycles;
  int                 stall_left;
  logic               burst_mode;
  int                 items_sent;

  qr_decomposition_gram_schmidt u_top (.*);

  qr_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: per-result stall draw, with bursts of no stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall || stall_left == 0) begin
      if ($urandom_range(0, 15) == 0) burst_mode <= ~burst_mode;
      stall_left <= burst_mode ? 0 : $urandom_range(0, 5);
      out_stall <= burst_mode ? 1'b0 : ($urandom_range(0, 5) != 0);
    end else begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_element(logic signed [31:0] v, bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int rows, int cols, int thr);
    drain();
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_THRESH, thr);
  endtask

  function automatic logic signed [31:0] rand_element(int mode);
    case (mode)
      0: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      1: return $urandom();
      default: case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 0;
        default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      endcase
    endcase
  endfunction

  task automatic send_matrix(int rows, int cols);
    logic signed [31:0] cur [32];
    int m, n, mode, src;
    bit no_gaps;
    m = rows == 0 ? 1 : (rows > 8 ? 8 : rows);
    n = cols == 0 ? 1 : (cols > 4 ? 4 : cols);
    mode = $urandom_range(0, 5);
    no_gaps = $urandom_range(0, 3) == 0;
    for (int c = 0; c < n; c++) begin
      src = (c > 0 && mode == 5) ? $urandom_range(0, c-1) : -1;
      for (int r = 0; r < m; r++) begin
        cur[c*8+r] = src >= 0 ? cur[src*8+r] : rand_element(mode < 3 ? 0 : mode - 2);
        send_element(cur[c*8+r], no_gaps);
      end
    end
  endtask

  initial begin
    int rows, cols, thr;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_mode = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 1x1 extremes and a zero column
    configure(1, 1, 0);
    send_element(32'sh7fffffff, 0);
    send_element(32'sh80000000, 0);
    send_element(0, 0);
    // zero sizes taken as one, unknown index ignored
    configure(0, 0, 0);
    write_reg(2'd3, 16'hffff);
    send_element(32'sh00010000, 0);
    // fewer rows than columns
    configure(2, 4, 0);
    for (int i = 0; i < 8; i++) send_element(i[0] ? 32'sh80000000 : 32'sh7fffffff, 0);
    // largest threshold with full-scale alternating columns
    configure(2, 2, 65535);
    for (int i = 0; i < 4; i++) send_element(i[0] ? 32'sh80000000 : 32'sh7fffffff, 0);
    // dependent column collapses to zero norm
    configure(3, 2, 0);
    for (int i = 0; i < 6; i++) send_element(((i % 3) + 1) * (i < 3 ? 1 : 2) <<< 16, 0);
    // oversized register values clamp to maximum
    configure(15, 7, 1);
    send_matrix(15, 7);

    while (items_sent < 380) begin
      rows = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8);
      cols = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4);
      case ($urandom_range(0, 3))
        0: thr = 0;
        1: thr = 65535;
        2: thr = $urandom_range(0, 2000);
        default: thr = $urandom_range(0, 65535);
      endcase
      configure(rows, cols, thr);
      repeat ($urandom_range(1, 3)) send_matrix(rows, cols);
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/qrgs_pkg.sv
rtl/qrgs_ram.sv
rtl/qr_decomposition_gram_schmidt.sv
rtl/qrgs_checker.sv
tb/qr_checker.sv
tb/tb_qr_decomposition_gram_schmidt.sv
